// ===== rtl/gef_pkg.sv =====
// ----------------------------------------------------------------------------
// gef_pkg
// Shared constants for the gradient edge filter: widths, limits, register map.
// ----------------------------------------------------------------------------
package gef_pkg;

    localparam int GEF_PIXEL_W       = 8;
    localparam int GEF_CFG_W         = 9;
    localparam int GEF_DATA_W        = 32;
    localparam int GEF_ADDR_W        = 3;
    localparam int GEF_MAX_WIDTH     = 256;
    localparam int GEF_MAX_HEIGHT    = 256;
    localparam int GEF_MIN_DIM       = 3;
    localparam int GEF_REG_SEL_BIT   = 2;

    localparam logic [GEF_CFG_W-1:0]   GEF_RESET_DIM = 9'd256;
    localparam logic [GEF_PIXEL_W-1:0] GEF_PIXEL_MAX = 8'hFF;

    // register index, taken from the word-select bit of paddr
    localparam logic GEF_REG_FRAME_WIDTH  = 1'b0;
    localparam logic GEF_REG_FRAME_HEIGHT = 1'b1;

endpackage

// ===== rtl/gef_ram.sv =====
// ----------------------------------------------------------------------------
// gef_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module gef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gradient_edge_filter.sv =====
// ----------------------------------------------------------------------------
// gradient_edge_filter
// Streaming edge detector: inverted, saturated |right-left| + |down-up|.
// ----------------------------------------------------------------------------
// Pixels of a grey frame enter on the s_ channel in raster order, one per
// request: s_tdata carries the grey level, s_tuser flags a drain request.
// Results leave on the m_ channel: m_tdata is 255 minus the saturated gradient
// of an interior pixel, or 255 minus the pixel itself on the frame border;
// m_tlast marks the final pixel of the frame.
// Results trail the input by one row plus one pixel; once the frame's last
// pixel is in, width+1 further requests (drain or not) push out the tail.
// Drain requests before the last pixel are taken and dropped.
// One request is taken per cycle while s_tready is high. A result passes
// from the request that completes it through the line-store read, then
// the output register.
// The receiver may stall at will; the output register holds the result and
// the input keeps flowing until the single pipeline stage behind it fills.
// Frame size is set over APB (frame_width at 0x0, frame_height at 0x4); any
// write restarts the frame. Reset clears the position counters and sets
// both sizes to 256. Line stores need no clearing.
// ----------------------------------------------------------------------------
module gradient_edge_filter
    import gef_pkg::*;
#(
    parameter int MAX_WIDTH = GEF_MAX_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: [7:0] pixel_in
    input  logic [7:0]             s_tdata,
    // s_tuser: [0] drain
    input  logic [0:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: [7:0] pixel_out
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [GEF_ADDR_W-1:0]  paddr,
    input  logic [GEF_DATA_W-1:0]  pwdata,
    output logic [GEF_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = (COL_W + 1 > GEF_CFG_W) ? COL_W + 1 : GEF_CFG_W;
    localparam int XW    = EW + 1;
    localparam int HW    = GEF_CFG_W;

    logic [GEF_CFG_W-1:0]   frame_width_reg;
    logic [GEF_CFG_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [HW-1:0]          row_reg, row_next;
    logic                   started_reg, started_next;

    logic [EW-1:0]          eff_w;
    logic [EW-1:0]          width_ext;
    logic [HW-1:0]          eff_h;
    logic                   cfg_wr;

    logic                   s_acc;
    logic                   work;
    logic                   tail;
    logic [COL_W-1:0]       cpos;
    logic                   emit;
    logic [HW-1:0]          orow;
    logic [EW-1:0]          ocol;
    logic                   interior;
    logic                   item_last;
    logic [EW-1:0]          col_inc;
    logic [GEF_PIXEL_W-1:0] bot;

    logic                   s1_valid_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [GEF_PIXEL_W-1:0] s1_bot_reg;
    logic                   s1_emit_reg;
    logic                   s1_interior_reg;
    logic                   s1_last_reg;
    logic                   s1_adv;

    logic [GEF_PIXEL_W-1:0] above_rdata;
    logic [GEF_PIXEL_W-1:0] two_rdata;
    logic [GEF_PIXEL_W-1:0] win_reg [4];

    logic [GEF_PIXEL_W-1:0] diff_h, diff_v;
    logic [GEF_PIXEL_W:0]   grad_sum;
    logic [GEF_PIXEL_W-1:0] grad_sat;
    logic [GEF_PIXEL_W-1:0] pix_out;

    logic                   m_valid_reg;
    logic [GEF_PIXEL_W-1:0] m_data_reg;
    logic                   m_last_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= GEF_RESET_DIM;
            frame_height_reg <= GEF_RESET_DIM;
        end else if (cfg_wr) begin
            case (paddr[GEF_REG_SEL_BIT])
                GEF_REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[GEF_CFG_W-1:0];
                GEF_REG_FRAME_HEIGHT: frame_height_reg <= pwdata[GEF_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[GEF_REG_SEL_BIT])
            GEF_REG_FRAME_WIDTH:  prdata = GEF_DATA_W'(frame_width_reg);
            GEF_REG_FRAME_HEIGHT: prdata = GEF_DATA_W'(frame_height_reg);
            default:              prdata = '0;
        endcase
    end

    assign width_ext = EW'(frame_width_reg);

    always_comb begin
        if (width_ext < EW'(GEF_MIN_DIM)) begin
            eff_w = EW'(GEF_MIN_DIM);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = width_ext;
        end
        if (frame_height_reg < HW'(GEF_MIN_DIM)) begin
            eff_h = HW'(GEF_MIN_DIM);
        end else if (frame_height_reg > HW'(GEF_MAX_HEIGHT)) begin
            eff_h = HW'(GEF_MAX_HEIGHT);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    // ---------------- request decode and position ----------------
    assign s1_adv   = !s1_emit_reg || !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;
    assign tail     = row_reg >= eff_h;
    assign work     = s_acc && (!s_tuser[0] || tail);
    assign bot      = tail ? '0 : s_tdata;

    always_comb begin
        cpos      = (EW'(col_reg) >= eff_w) ? '0 : col_reg;
        emit      = started_reg || (row_reg >= HW'(2)) || (row_reg == HW'(1) && cpos != '0);
        if (cpos == '0) begin
            orow = row_reg - HW'(2);
            ocol = eff_w - EW'(1);
        end else begin
            orow = row_reg - HW'(1);
            ocol = EW'(cpos) - EW'(1);
        end
        interior  = (orow >= HW'(1)) && ({1'b0, orow} + (HW+1)'(2) <= {1'b0, eff_h})
                 && (ocol >= EW'(1)) && ({1'b0, ocol} + XW'(2) <= {1'b0, eff_w});
        item_last = emit && (orow == eff_h - HW'(1)) && (ocol == eff_w - EW'(1));
        col_inc   = EW'(cpos) + EW'(1);

        col_next     = col_reg;
        row_next     = row_reg;
        started_next = started_reg;
        if (cfg_wr) begin
            col_next     = '0;
            row_next     = '0;
            started_next = 1'b0;
        end else if (work) begin
            if (item_last) begin
                col_next     = '0;
                row_next     = '0;
                started_next = 1'b0;
            end else begin
                started_next = started_reg || emit;
                if (col_inc >= eff_w) begin
                    col_next = '0;
                    row_next = row_reg + HW'(1);
                end else begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            started_reg <= started_next;
        end
    end

    // ---------------- line stores ----------------
    gef_ram #(
        .WIDTH (GEF_PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .aclk  (aclk),
        .we    (work),
        .waddr (cpos),
        .wdata (bot),
        .re    (work),
        .raddr (cpos),
        .rdata (above_rdata)
    );

    gef_ram #(
        .WIDTH (GEF_PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .aclk  (aclk),
        .we    (s1_valid_reg && s1_adv),
        .waddr (s1_col_reg),
        .wdata (above_rdata),
        .re    (work),
        .raddr (cpos),
        .rdata (two_rdata)
    );

    // ---------------- window stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else if (work) begin
            s1_valid_reg <= 1'b1;
            s1_emit_reg  <= emit;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            s1_col_reg      <= cpos;
            s1_bot_reg      <= bot;
            s1_interior_reg <= interior;
            s1_last_reg     <= item_last;
        end
    end

    // win: 0 up, 1 centre, 2 down, 3 left
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_valid_reg && s1_adv) begin
            win_reg[3] <= win_reg[1];
            win_reg[0] <= two_rdata;
            win_reg[1] <= above_rdata;
            win_reg[2] <= s1_bot_reg;
        end
    end

    always_comb begin
        diff_h   = (above_rdata > win_reg[3]) ? above_rdata - win_reg[3]
                                              : win_reg[3] - above_rdata;
        diff_v   = (win_reg[2] > win_reg[0]) ? win_reg[2] - win_reg[0]
                                             : win_reg[0] - win_reg[2];
        grad_sum = {1'b0, diff_h} + {1'b0, diff_v};
        grad_sat = grad_sum[GEF_PIXEL_W] ? GEF_PIXEL_MAX : grad_sum[GEF_PIXEL_W-1:0];
        pix_out  = s1_interior_reg ? GEF_PIXEL_MAX - grad_sat : GEF_PIXEL_MAX - win_reg[1];
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_adv && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv && s1_emit_reg) begin
            m_data_reg <= pix_out;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        work && item_last && !cfg_wr |=> (col_reg == '0 && row_reg == '0 && !started_reg))
        else $error("frame end did not restart the counters");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(col_reg) < eff_w)
        else $error("column counter beyond frame width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr && $past(!cfg_wr) |-> {1'b0, row_reg} <= {1'b0, eff_h} + (HW+1)'(1))
        else $error("row counter beyond frame tail");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_emit_reg && m_valid_reg && !m_tready |=> s1_valid_reg)
        else $error("window stage dropped a result under stall");

endmodule

// ===== tb/gef_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gef_stream_checker
// Watches the pixel and result streams and the APB port of the edge filter.
// ----------------------------------------------------------------------------
// Every pixel request taken on the s_ channel runs through a cycle-free model
// of the filter: two row stores, a four-pixel window, the position counters
// and the frame size seen on APB writes. Each request that completes a result
// queues the expected inverted gradient or inverted border pixel and its
// end-of-frame mark; each m_ channel result is compared with the oldest one.
// ----------------------------------------------------------------------------
module gef_stream_checker
    import gef_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_tdata,
    input  logic [0:0]             s_tuser,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             m_tdata,
    input  logic                   m_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [GEF_ADDR_W-1:0]  paddr,
    input  logic [GEF_DATA_W-1:0]  pwdata,
    input  logic                   pready,
    output int                     error_count,
    output int                     pending_results
);

    typedef struct packed {
        logic [7:0] level;
        logic       last;
    } edge_px_t;

    edge_px_t expected_edges [$];
    edge_px_t want;

    logic [7:0]           row_one_up [GEF_MAX_WIDTH];
    logic [7:0]           row_two_up [GEF_MAX_WIDTH];
    logic [7:0]           win_up;
    logic [7:0]           win_mid;
    logic [7:0]           win_down;
    logic [7:0]           win_left;
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic                 emitting;
    logic [GEF_CFG_W-1:0] cfg_width;
    logic [GEF_CFG_W-1:0] cfg_height;

    initial begin
        error_count     = 0;
        pending_results = 0;
    end

    function automatic void restart_frame();
        col_pos  = 0;
        row_pos  = 0;
        emitting = 1'b0;
    endfunction

    function automatic void predict_edge_pixel(input logic [7:0] level_in,
                                               input logic drain_req);
        int unsigned w, h, r, c;
        int unsigned px_up2, px_up1, px_new;
        int unsigned lft, up, ctr, dn, rgt;
        int unsigned orow, ocol, mag;
        logic        tail, fires;
        edge_px_t    res;

        w = (cfg_width < GEF_MIN_DIM) ? GEF_MIN_DIM :
            (cfg_width > GEF_MAX_WIDTH) ? GEF_MAX_WIDTH : cfg_width;
        h = (cfg_height < GEF_MIN_DIM) ? GEF_MIN_DIM :
            (cfg_height > GEF_MAX_HEIGHT) ? GEF_MAX_HEIGHT : cfg_height;
        r = row_pos;
        c = col_pos;
        tail = (r >= h);

        // drop drain requests while pixels are still due
        if (drain_req && !tail) return;
        if (c >= w) c = 0;

        px_new = tail ? 0 : level_in;
        px_up2 = row_two_up[c];
        px_up1 = row_one_up[c];
        row_two_up[c] = px_up1[7:0];
        row_one_up[c] = px_new[7:0];

        lft = win_left;
        up  = win_up;
        ctr = win_mid;
        dn  = win_down;
        rgt = px_up1;
        win_left = win_mid;
        win_up   = px_up2[7:0];
        win_mid  = px_up1[7:0];
        win_down = px_new[7:0];

        fires = emitting || r >= 2 || (r == 1 && c >= 1);
        if (fires) begin
            if (c == 0) begin
                orow = r - 2;
                ocol = w - 1;
            end else begin
                orow = r - 1;
                ocol = c - 1;
            end
            if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
                mag = ((rgt > lft) ? rgt - lft : lft - rgt) +
                      ((dn > up) ? dn - up : up - dn);
                if (mag > GEF_PIXEL_MAX) mag = GEF_PIXEL_MAX;
            end else begin
                mag = ctr;
            end
            res.level = GEF_PIXEL_MAX - 8'(mag);
            res.last  = (orow == h - 1) && (ocol == w - 1);
            expected_edges.push_back(res);
            emitting = 1'b1;
            if (res.last) begin
                restart_frame();
                return;
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r & 32'h1FF;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GEF_MAX_WIDTH; i++) begin
                row_one_up[i] = '0;
                row_two_up[i] = '0;
            end
            win_up     = '0;
            win_mid    = '0;
            win_down   = '0;
            win_left   = '0;
            cfg_width  = GEF_RESET_DIM;
            cfg_height = GEF_RESET_DIM;
            restart_frame();
            expected_edges.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[GEF_REG_SEL_BIT] == GEF_REG_FRAME_WIDTH) begin
                    cfg_width = pwdata[GEF_CFG_W-1:0];
                end else begin
                    cfg_height = pwdata[GEF_CFG_W-1:0];
                end
                restart_frame();
            end
            if (s_tvalid && s_tready) begin
                predict_edge_pixel(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_edges.size() == 0) begin
                    if (error_count < 10) begin
                        $display("%0t: unexpected result pixel_out=%0d last=%0b",
                                 $time, m_tdata, m_tlast);
                    end
                    error_count++;
                end else begin
                    want = expected_edges.pop_front();
                    if (m_tdata !== want.level || m_tlast !== want.last) begin
                        if (error_count < 10) begin
                            $display("%0t: mismatch pixel_out exp %0d got %0d, last exp %0b got %0b",
                                     $time, want.level, m_tdata, want.last, m_tlast);
                        end
                        error_count++;
                    end
                end
            end
        end
        pending_results = expected_edges.size();
    end

endmodule

// ===== tb/gradient_edge_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_filter_test
// Stimulus and verdict for the gradient edge filter.
// ----------------------------------------------------------------------------
// Streams grey frames into the filter: a partial frame at the reset size, a
// small hand-made frame with saturating gradients, drains and a pixel in the
// tail, a tall narrow full frame, a frame broken off at clamped out-of-range
// sizes, then random small frames with stray drains, broken-off frames and
// out-of-range size writes. Sender gaps and receiver stalls vary between jobs.
// A separate checker predicts and compares; this module only drives and
// reports.
// ----------------------------------------------------------------------------
module gradient_edge_filter_test;
    import gef_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [GEF_ADDR_W-1:0] paddr;
    logic [GEF_DATA_W-1:0] pwdata;
    logic [GEF_DATA_W-1:0] prdata;
    logic                  pready;

    int          error_count;
    int          pending_results;
    int          src_idle_pct;
    int          sink_stall_pct;
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned counted_items;
    int unsigned cycles;

    gradient_edge_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gef_stream_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v < GEF_MIN_DIM) ? GEF_MIN_DIM : (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] pick_level();
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? GEF_PIXEL_MAX : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic set_mode(input int k);
        case (k % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
            default: begin src_idle_pct = 9; sink_stall_pct = 9; end
        endcase
    endtask

    task automatic send_request(input logic [7:0] level, input logic drain);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= level;
        s_tuser  <= drain;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic reg_sel, input int unsigned value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= GEF_ADDR_W'(reg_sel) << GEF_REG_SEL_BIT;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_frame(input int unsigned wv, input int unsigned hv);
        write_reg(GEF_REG_FRAME_WIDTH, wv);
        write_reg(GEF_REG_FRAME_HEIGHT, hv);
        frame_w = clamp_dim(wv, GEF_MAX_WIDTH);
        frame_h = clamp_dim(hv, GEF_MAX_HEIGHT);
    endtask

    // hold until every expected result is out, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_frame(input int unsigned pixels, input bit with_tail);
        int unsigned i;
        for (i = 0; i < pixels; i++) begin
            if ($urandom_range(0, 19) == 0) send_request(pick_level(), 1'b1);
            send_request(pick_level(), 1'b0);
            counted_items++;
        end
        if (with_tail) begin
            for (i = 0; i <= frame_w; i++) begin
                send_request(pick_level(), $urandom_range(0, 4) != 0);
                counted_items++;
            end
        end
    endtask

    initial begin
        logic [7:0]  dir_px [12];
        int unsigned rand_base;
        int unsigned nframes;
        int unsigned f;
        int          job;

        aresetn        = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tvalid       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        counted_items  = 0;
        frame_w        = GEF_MAX_WIDTH;
        frame_h        = GEF_MAX_HEIGHT;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset size, broken off just after the first row of results starts
        set_mode(1);
        run_frame(270, 1'b0);
        wait_drained();

        // small frame with saturating interior, stray drains and a tail pixel
        set_mode(0);
        set_frame(4, 3);
        dir_px = '{8'd17, 8'd0, 8'd0, 8'd200, 8'd0, 8'd0, 8'd255, 8'd255,
                   8'd128, 8'd255, 8'd255, 8'd1};
        send_request(8'd0, 1'b1);
        for (int i = 0; i < 12; i++) begin
            send_request(dir_px[i], 1'b0);
            if (i == 0) send_request(GEF_PIXEL_MAX, 1'b1);
        end
        send_request(8'd0, 1'b1);
        send_request(8'd99, 1'b0);
        send_request(8'd0, 1'b1);
        send_request(8'd0, 1'b1);
        send_request(8'd0, 1'b1);
        send_request(8'd0, 1'b1);
        wait_drained();

        // tall narrow full frame, then a broken one at clamped sizes
        set_mode(2);
        set_frame(3, 40);
        run_frame(frame_w * frame_h, 1'b1);
        wait_drained();
        set_mode(3);
        set_frame(300, 0);
        run_frame(260, 1'b0);
        wait_drained();

        rand_base = counted_items;
        job = 0;
        while (counted_items < rand_base + 250) begin
            set_mode(job);
            job++;
            set_frame($urandom_range(0, 14), $urandom_range(0, 12));
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                if ($urandom_range(0, 7) == 0) begin
                    run_frame($urandom_range(1, frame_w * frame_h - 1), 1'b0);
                    f = nframes;
                end else begin
                    run_frame(frame_w * frame_h, 1'b1);
                end
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== gradient_edge_filter.f =====
rtl/gef_pkg.sv
rtl/gef_ram.sv
rtl/gradient_edge_filter.sv
tb/gef_stream_checker.sv
tb/gradient_edge_filter_test.sv
